FILE: design/skv_pkg.sv
package skv_pkg;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_NOT_FOUND    = 3'd1,
        ST_OVERFLOW     = 3'd2,
        ST_SWITCH       = 3'd3,
        ST_OUT_OF_RANGE = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        REG_DEFAULT = 3'd0,
        REG_LOWER   = 3'd1,
        REG_UPPER   = 3'd2,
        REG_SWITCH  = 3'd3,
        REG_LEAF    = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic        mode;
        logic [31:0] lookup_key;
        logic [63:0] data_value;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] read_value;
        logic [8:0]  position;
        logic [8:0]  fill_count;
        logic        overflowed;
    } rsp_t;

    // request classified by the front end
    typedef struct packed {
        logic        is_get;
        logic        out_of_range;
        logic        is_default;
        logic [31:0] key;
        logic [63:0] value;
    } cmd_t;

    typedef struct packed {
        logic [63:0] default_value;
        logic [31:0] lower_key;
        logic [31:0] upper_key;
        logic        allow_switch;
        logic        leaf_mode;
    } cfg_t;

endpackage

FILE: design/skv_if.sv
interface skv_req_if;
    import skv_pkg::*;
    logic valid;
    logic ready;
    req_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface skv_rsp_if;
    import skv_pkg::*;
    logic valid;
    logic ready;
    rsp_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: design/skv_front.sv
module skv_front (
    input  logic         clk,
    input  logic         rst_n,
    input  skv_pkg::cfg_t cfg,
    skv_req_if.sink      req,
    output logic         cmd_valid,
    output skv_pkg::cmd_t cmd,
    input  logic         cmd_ready
);
    import skv_pkg::*;

    // two-entry queue toward the back end
    cmd_t       q_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    cmd_t       c_in;

    always_comb
    begin
        c_in.is_get       = req.payload.mode;
        c_in.key          = req.payload.lookup_key;
        c_in.value        = req.payload.data_value;
        c_in.out_of_range = (req.payload.lookup_key < cfg.lower_key) ||
                            (req.payload.lookup_key >= cfg.upper_key);
        c_in.is_default   = cfg.leaf_mode && (req.payload.data_value == cfg.default_value);
    end

    assign req.ready = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            q_reg[wp_reg] <= c_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                wp_reg <= ~wp_reg;
            end
            if (cmd_valid && cmd_ready)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, req.valid && req.ready} - {1'b0, cmd_valid && cmd_ready};
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("queue count out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2 && !(cmd_valid && cmd_ready)) |=> cnt_reg == 2'd2)
        else $error("full queue drained without a pop");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0) |-> !cmd_valid)
        else $error("empty queue shows valid");
endmodule

FILE: design/skv_back.sv
module skv_back #(
    parameter int CAPACITY = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    input  skv_pkg::cfg_t cfg,
    input  logic          cmd_valid,
    input  skv_pkg::cmd_t cmd,
    output logic          cmd_ready,
    skv_rsp_if.source     rsp
);
    import skv_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_RD    = 8'b00000010,
        S_CMP   = 8'b00000100,
        S_ACT   = 8'b00001000,
        S_SHRD  = 8'b00010000,
        S_SHWR  = 8'b00100000,
        S_OUT   = 8'b01000000,
        S_INS   = 8'b10000000
    } state_t;

    state_t      state_reg;
    logic [31:0] key_mem [CAPACITY];
    logic [63:0] val_mem [CAPACITY];
    logic [31:0] kq_reg;
    logic [63:0] vq_reg;
    cmd_t        c_reg;
    logic [CW:0] lo_reg, hi_reg;
    logic [CW-1:0] mid_reg, cnt_reg, sh_reg, pos_reg;
    logic        found_reg, ins_reg;
    logic        ovf_reg;
    logic [31:0] ovk_reg;
    logic [63:0] ovv_reg;
    logic [CW-1:0] ovi_reg;
    logic        rvalid_reg;
    rsp_t        rsp_reg;
    logic [2:0]  st;
    logic [2:0]  st_reg;
    logic [CW:0] sum;

    // memory: one read, one write port
    logic          we;
    logic [AW-1:0] wa, ra;
    logic [31:0]   wk;
    logic [63:0]   wv;

    assign sum = lo_reg + hi_reg;
    assign cmd_ready = (state_reg == S_IDLE);
    assign rsp.valid = rvalid_reg;
    assign rsp.payload = rsp_reg;

    // read address: probe point during the search, neighbor during a shift
    always_comb
    begin
        ra = mid_reg[AW-1:0];
        if (state_reg == S_RD)
        begin
            ra = sum[AW:1];
        end
        else if (state_reg == S_SHRD)
        begin
            ra = ins_reg ? AW'(sh_reg - 1'b1) : AW'(sh_reg + 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            key_mem[wa] <= wk;
            val_mem[wa] <= wv;
        end
        kq_reg <= key_mem[ra];
        vq_reg <= val_mem[ra];
    end

    always_comb
    begin
        we = 1'b0;
        wa = pos_reg[AW-1:0];
        wk = c_reg.key;
        wv = c_reg.value;
        if (state_reg == S_SHWR)
        begin
            we = 1'b1;
            wa = sh_reg[AW-1:0];
            wk = kq_reg;
            wv = vq_reg;
        end
        else if (state_reg == S_INS)
        begin
            we = 1'b1;
        end
        else if (state_reg == S_ACT && !c_reg.out_of_range && !c_reg.is_get)
        begin
            if (found_reg && !c_reg.is_default)
            begin
                we = 1'b1;
            end
            else if (!found_reg && !c_reg.is_default && cnt_reg < CW'(CAPACITY)
                     && pos_reg == cnt_reg)
            begin
                we = 1'b1;
            end
        end
    end

    always_comb
    begin
        if (c_reg.out_of_range)
        begin
            st = ST_OUT_OF_RANGE;
        end
        else if (c_reg.is_get)
        begin
            st = found_reg ? ST_OK : ST_NOT_FOUND;
        end
        else if (!found_reg && !c_reg.is_default && cnt_reg >= CW'(CAPACITY))
        begin
            st = (cfg.leaf_mode && cfg.allow_switch) ? ST_SWITCH : ST_OVERFLOW;
        end
        else
        begin
            st = ST_OK;
        end
    end

    // binary search, then insert/delete shift one entry per read (S_SHRD) and write (S_SHWR) state pair
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            ovf_reg    <= 1'b0;
            ovk_reg    <= '0;
            ovv_reg    <= '0;
            ovi_reg    <= '0;
            rvalid_reg <= 1'b0;
            c_reg      <= '0;
            lo_reg     <= '0;
            hi_reg     <= '0;
            mid_reg    <= '0;
            sh_reg     <= '0;
            pos_reg    <= '0;
            found_reg  <= 1'b0;
            ins_reg    <= 1'b0;
            st_reg     <= '0;
            rsp_reg    <= '0;
        end
        else
        begin
            if (rsp.valid && rsp.ready && state_reg != S_OUT)
            begin
                rvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        c_reg     <= cmd;
                        lo_reg    <= '0;
                        hi_reg    <= {1'b0, cnt_reg};
                        found_reg <= 1'b0;
                        state_reg <= S_RD;
                    end
                end
                S_RD:
                begin
                    if (lo_reg >= hi_reg)
                    begin
                        pos_reg   <= lo_reg[CW-1:0];
                        state_reg <= S_ACT;
                    end
                    else
                    begin
                        mid_reg   <= sum[CW:1];
                        state_reg <= S_CMP;
                    end
                end
                S_CMP:
                begin
                    if (kq_reg == c_reg.key)
                    begin
                        found_reg <= 1'b1;
                        pos_reg   <= mid_reg;
                        state_reg <= S_ACT;
                    end
                    else
                    begin
                        if (kq_reg > c_reg.key)
                        begin
                            hi_reg <= {1'b0, mid_reg};
                        end
                        else
                        begin
                            lo_reg <= {1'b0, mid_reg} + 1'b1;
                        end
                        state_reg <= S_RD;
                    end
                end
                S_ACT:
                begin
                    // status is fixed here, before the fill count moves
                    st_reg    <= st;
                    state_reg <= S_OUT;
                    if (!c_reg.out_of_range && !c_reg.is_get)
                    begin
                        if (found_reg && c_reg.is_default)
                        begin
                            cnt_reg <= cnt_reg - 1'b1;
                            ins_reg <= 1'b0;
                            sh_reg  <= pos_reg;
                            if (pos_reg + 1'b1 < cnt_reg)
                            begin
                                state_reg <= S_SHRD;
                            end
                        end
                        else if (!found_reg && !c_reg.is_default)
                        begin
                            if (cnt_reg >= CW'(CAPACITY))
                            begin
                                ovf_reg <= 1'b1;
                                ovk_reg <= c_reg.key;
                                ovv_reg <= c_reg.value;
                                ovi_reg <= pos_reg;
                            end
                            else
                            begin
                                cnt_reg <= cnt_reg + 1'b1;
                                ins_reg <= 1'b1;
                                sh_reg  <= cnt_reg;
                                if (pos_reg != cnt_reg)
                                begin
                                    state_reg <= S_SHRD;
                                end
                            end
                        end
                    end
                end
                S_SHRD:
                begin
                    state_reg <= S_SHWR;
                end
                S_SHWR:
                begin
                    if (ins_reg)
                    begin
                        sh_reg <= sh_reg - 1'b1;
                        if (sh_reg - 1'b1 == pos_reg)
                        begin
                            state_reg <= S_INS;
                        end
                        else
                        begin
                            state_reg <= S_SHRD;
                        end
                    end
                    else
                    begin
                        sh_reg <= sh_reg + 1'b1;
                        state_reg <= (sh_reg + 2'd2 < cnt_reg + 1'b1) ? S_SHRD : S_OUT;
                    end
                end
                // place the new entry in the gap opened by the shift
                S_INS:
                begin
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!rvalid_reg || rsp.ready)
                    begin
                        rvalid_reg            <= 1'b1;
                        rsp_reg.status        <= st_reg;
                        rsp_reg.read_value    <= (c_reg.is_get && found_reg && !c_reg.out_of_range)
                                                 ? vq_reg : cfg.default_value;
                        rsp_reg.position      <= 9'(pos_reg);
                        rsp_reg.fill_count    <= 9'(cnt_reg);
                        rsp_reg.overflowed    <= ovf_reg;
                        state_reg             <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= CW'(CAPACITY))
        else $error("fill count beyond capacity");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> (mid_reg < cnt_reg))
        else $error("search read beyond fill");
    assert property (@(posedge clk) disable iff (!rst_n) $fell(ovf_reg) == 1'b0)
        else $error("overflow flag cleared");
endmodule

FILE: design/sorted_kv_block_with_overflow.sv
// channel | dir | payload
// req     | in  | mode, lookup_key, data_value
// rsp     | out | status, read_value, position, fill_count, overflowed
// apb     | in  | five registers at 8*i, 64-bit data
// a request takes a read and a compare state per search probe, then the result,
// plus a read and a write state per entry moved on an insert or delete (one memory port)
// and an insert state to place an inserted entry after a shift
// a two-entry queue takes requests while the back end works
// the response register holds a result until taken; the back end stalls on it
// reset is asynchronous; the table memory needs no clearing
module sorted_kv_block_with_overflow #(
    parameter int CAPACITY = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    skv_req_if.sink     req,
    skv_rsp_if.source   rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import skv_pkg::*;

    cfg_t     cfg_reg;
    logic     cmd_valid, cmd_ready;
    cmd_t     cmd;
    reg_idx_t idx;

    assign pready = 1'b1;
    assign idx = reg_idx_t'(paddr[5:3]);

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.default_value <= '0;
            cfg_reg.lower_key     <= '0;
            cfg_reg.upper_key     <= 32'hFFFF_FFFF;
            cfg_reg.allow_switch  <= 1'b0;
            cfg_reg.leaf_mode     <= 1'b1;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (idx)
                REG_DEFAULT: cfg_reg.default_value <= pwdata;
                REG_LOWER:   cfg_reg.lower_key     <= pwdata[31:0];
                REG_UPPER:   cfg_reg.upper_key     <= pwdata[31:0];
                REG_SWITCH:  cfg_reg.allow_switch  <= pwdata[0];
                REG_LEAF:    cfg_reg.leaf_mode     <= pwdata[0];
                default:     ;
            endcase
        end
    end

    // register reads
    always_comb
    begin
        unique case (idx)
            REG_DEFAULT: prdata = cfg_reg.default_value;
            REG_LOWER:   prdata = {32'd0, cfg_reg.lower_key};
            REG_UPPER:   prdata = {32'd0, cfg_reg.upper_key};
            REG_SWITCH:  prdata = {63'd0, cfg_reg.allow_switch};
            REG_LEAF:    prdata = {63'd0, cfg_reg.leaf_mode};
            default:     prdata = '0;
        endcase
    end

    skv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .req       (req),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready)
    );

    skv_back #(.CAPACITY(CAPACITY)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_ready (cmd_ready),
        .rsp       (rsp)
    );
endmodule

FILE: sim/tb_sorted_kv_block_with_overflow.sv
module tb_sorted_kv_block_with_overflow;
    import skv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP = 256;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    skv_req_if req_ch ();
    skv_rsp_if rsp_ch ();

    sorted_kv_block_with_overflow #(.CAPACITY(CAP)) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch.sink),
        .rsp     (rsp_ch.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow of the table and registers
    logic [31:0] tbl_key [CAP];
    logic [63:0] tbl_val [CAP];
    int          tbl_count;
    logic        ovf_flag;
    logic [63:0] cfg_default;
    logic [31:0] cfg_lower;
    logic [31:0] cfg_upper;
    logic        cfg_switch;
    logic        cfg_leaf;

    rsp_t        expected_rsp_q [$];
    int          error_count;
    int          rsp_count;
    int          req_count;
    bit          long_hold;
    bit          stall_enable;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watchdog
    initial
    begin
        #100ms;
        $display("tb_sorted_kv_block_with_overflow: done, errors");
        $finish;
    end

    // compute the response for one request and update the shadow table
    function automatic rsp_t predict_kv(req_t r);
        rsp_t        res;
        int          lo;
        int          hi;
        int          mid;
        bit          found;
        int          pos;
        logic [2:0]  st;
        logic [63:0] rd;
        lo = 0;
        hi = tbl_count - 1;
        found = 1'b0;
        pos = 0;
        while (lo <= hi && !found)
        begin
            mid = (lo + hi) / 2;
            if (tbl_key[mid] == r.lookup_key)
            begin
                found = 1'b1;
                pos = mid;
            end
            else if (tbl_key[mid] > r.lookup_key)
                hi = mid - 1;
            else
                lo = mid + 1;
        end
        if (!found)
            pos = lo;
        rd = cfg_default;
        st = ST_OK;
        if (r.lookup_key < cfg_lower || r.lookup_key >= cfg_upper)
            st = ST_OUT_OF_RANGE;
        else if (r.mode)
        begin
            if (found)
                rd = tbl_val[pos];
            else
                st = ST_NOT_FOUND;
        end
        else if (found)
        begin
            if (cfg_leaf && r.data_value == cfg_default)
            begin
                for (int i = pos; i < tbl_count - 1; i++)
                begin
                    tbl_key[i] = tbl_key[i + 1];
                    tbl_val[i] = tbl_val[i + 1];
                end
                tbl_count--;
            end
            else
                tbl_val[pos] = r.data_value;
        end
        else if (cfg_leaf && r.data_value == cfg_default)
            st = ST_OK;
        else if (tbl_count >= CAP)
        begin
            ovf_flag = 1'b1;
            st = (cfg_leaf && cfg_switch) ? ST_SWITCH : ST_OVERFLOW;
        end
        else
        begin
            for (int i = tbl_count; i > pos; i--)
            begin
                tbl_key[i] = tbl_key[i - 1];
                tbl_val[i] = tbl_val[i - 1];
            end
            tbl_key[pos] = r.lookup_key;
            tbl_val[pos] = r.data_value;
            tbl_count++;
        end
        res.status = st;
        res.read_value = rd;
        res.position = pos[8:0];
        res.fill_count = tbl_count[8:0];
        res.overflowed = ovf_flag;
        return res;
    endfunction

    // register write over apb, block idle
    task automatic write_reg(reg_idx_t idx, logic [63:0] data);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = 6'(idx) << 3;
        pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            REG_DEFAULT: cfg_default = data;
            REG_LOWER:   cfg_lower = data[31:0];
            REG_UPPER:   cfg_upper = data[31:0];
            REG_SWITCH:  cfg_switch = data[0];
            REG_LEAF:    cfg_leaf = data[0];
            default:     ;
        endcase
    endtask

    // offer one request, with an optional random gap first
    task automatic send_request(logic m, logic [31:0] k, logic [63:0] v, int gap);
        req_t r;
        r.mode = m;
        r.lookup_key = k;
        r.data_value = v;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.payload <= r;
        do @(posedge clk); while (!req_ch.ready);
        expected_rsp_q.insert(expected_rsp_q.size(), predict_kv(r));
        req_count++;
        @(negedge clk);
    endtask

    task automatic drain_and_idle();
        req_ch.valid <= 1'b0;
        while (expected_rsp_q.size() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    // response checker
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            rsp_count++;
            if (expected_rsp_q.size() == 0)
            begin
                $display("%0t: unexpected response %p", $time, rsp_ch.payload);
                error_count++;
            end
            else
            begin
                rsp_t e;
                e = expected_rsp_q.pop_front();
                if (rsp_ch.payload.status !== e.status)
                begin
                    $display("%0t: status exp %0d got %0d", $time, e.status,
                             rsp_ch.payload.status);
                    error_count++;
                end
                if (rsp_ch.payload.read_value !== e.read_value)
                begin
                    $display("%0t: read_value exp %h got %h", $time, e.read_value,
                             rsp_ch.payload.read_value);
                    error_count++;
                end
                if (rsp_ch.payload.position !== e.position)
                begin
                    $display("%0t: position exp %0d got %0d", $time, e.position,
                             rsp_ch.payload.position);
                    error_count++;
                end
                if (rsp_ch.payload.fill_count !== e.fill_count)
                begin
                    $display("%0t: fill_count exp %0d got %0d", $time, e.fill_count,
                             rsp_ch.payload.fill_count);
                    error_count++;
                end
                if (rsp_ch.payload.overflowed !== e.overflowed)
                begin
                    $display("%0t: overflowed exp %0d got %0d", $time, e.overflowed,
                             rsp_ch.payload.overflowed);
                    error_count++;
                end
            end
        end
    end

    // receiver stall pattern, plus a long hold when asked
    initial
    begin
        int hold;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                rsp_ch.ready <= 1'b0;
                for (hold = 0; hold < 400; hold++)
                    @(negedge clk);
                long_hold = 1'b0;
            end
            if (!stall_enable)
                rsp_ch.ready <= 1'b1;
            else
                rsp_ch.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    function automatic int pick_gap();
        return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
    endfunction

    function automatic logic [31:0] pick_key(logic [31:0] lo, logic [31:0] span);
        return lo + $urandom_range(0, span);
    endfunction

    // directed: extremes, both operations, deletes and range checks
    task automatic test_directed();
        send_request(1'b1, 32'h0, 64'h0, 0);
        send_request(1'b0, 32'hFFFF_FFFF, 64'h1, 0);
        send_request(1'b0, 32'h0, 64'hFFFF_FFFF_FFFF_FFFF, 0);
        send_request(1'b0, 32'h8000_0000, 64'h8000_0000_0000_0000, 0);
        send_request(1'b0, 32'h1234, 64'h0, 0);
        send_request(1'b1, 32'hFFFF_FFFE, 64'h0, 0);
        send_request(1'b1, 32'h0, 64'h5, 0);
        send_request(1'b0, 32'h8000_0000, 64'h7, 0);
        send_request(1'b0, 32'h8000_0000, 64'h0, 0);
        send_request(1'b1, 32'h8000_0000, 64'h0, 0);
        drain_and_idle();
        write_reg(REG_LOWER, 64'h10);
        write_reg(REG_UPPER, 64'h20);
        send_request(1'b0, 32'hF, 64'h3, 0);
        send_request(1'b1, 32'h20, 64'h3, 0);
        send_request(1'b0, 32'h10, 64'h3, 0);
        send_request(1'b1, 32'h1F, 64'h3, 0);
        send_request(1'b1, 32'h10, 64'h3, 0);
        drain_and_idle();
        write_reg(REG_LOWER, 64'h0);
        write_reg(REG_UPPER, 64'hFFFF_FFFF);
        write_reg(REG_DEFAULT, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(REG_LEAF, 64'h0);
        send_request(1'b0, 32'h55, 64'hFFFF_FFFF_FFFF_FFFF, 0);
        send_request(1'b1, 32'h55, 64'h0, 0);
        send_request(1'b1, 32'h56, 64'h0, 0);
        drain_and_idle();
    endtask

    // random traffic in a key window, bursts and gaps
    task automatic test_random(int n, logic [31:0] lo, logic [31:0] span, int put_pct);
        logic [63:0] v;
        int          gap;
        for (int i = 0; i < n; i++)
        begin
            gap = pick_gap();
            case ($urandom_range(0, 9))
                0:       v = cfg_default;
                1:       v = {$urandom, $urandom};
                default: v = {32'h0, $urandom} ^ {$urandom, 32'h0};
            endcase
            send_request(($urandom_range(0, 99) >= put_pct),
                         ($urandom_range(0, 19) == 0) ? $urandom : pick_key(lo, span),
                         v, gap);
        end
        drain_and_idle();
    endtask

    // fill the table beyond capacity under a long receiver hold
    task automatic test_full_table(logic sw);
        write_reg(REG_SWITCH, {63'h0, sw});
        long_hold = 1'b1;
        for (int i = 0; i < CAP + 20; i++)
            send_request(1'b0, $urandom, {$urandom, $urandom | 32'h1}, 0);
        test_random(150, 32'h0, 32'hFFFF_FFFF, 60);
    endtask

    initial
    begin
        error_count = 0;
        rsp_count = 0;
        req_count = 0;
        long_hold = 1'b0;
        stall_enable = 1'b0;
        tbl_count = 0;
        ovf_flag = 1'b0;
        cfg_default = 64'h0;
        cfg_lower = 32'h0;
        cfg_upper = 32'hFFFF_FFFF;
        cfg_switch = 1'b0;
        cfg_leaf = 1'b1;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        rst_n = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        test_directed();
        stall_enable = 1'b1;
        test_random(500, 32'h100, 32'd300, 60);
        write_reg(REG_LEAF, 64'h1);
        write_reg(REG_DEFAULT, 64'h0);
        test_random(500, 32'h100, 32'd300, 55);
        test_full_table(1'b1);
        write_reg(REG_LEAF, 64'h0);
        test_full_table(1'b0);
        write_reg(REG_LEAF, 64'h1);
        write_reg(REG_LOWER, 64'h4000);
        write_reg(REG_UPPER, 64'h4100);
        write_reg(REG_DEFAULT, 64'h0000_0000_0000_0003);
        test_random(300, 32'h3FF0, 32'h120, 50);

        $display("covered %0d requests and %0d responses: puts, gets, deletes,",
                 req_count, rsp_count);
        $display("key bounds, both default modes and full table with overflow");
        if (error_count == 0)
            $display("tb_sorted_kv_block_with_overflow: done, clean");
        else
            $display("tb_sorted_kv_block_with_overflow: done, errors");
        $finish;
    end

endmodule

FILE: sim.f
design/skv_pkg.sv
design/skv_if.sv
design/skv_front.sv
design/skv_back.sv
design/sorted_kv_block_with_overflow.sv
sim/tb_sorted_kv_block_with_overflow.sv
